>>> rtl/rhss_pkg.sv
// shared constants, types and modular arithmetic helpers for the rolling hash search
`timescale 1ns / 1ps
package rhss_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 64;
  localparam longint unsigned MAX_TEXT_DEF = 64'd65536;

  localparam int CMD_W  = 2;
  localparam int CODE_W = 5;
  localparam int POS_W  = 16;
  localparam int CNT_W  = 17;
  localparam int HASH_W = 30;
  localparam int MULB_W = 6;

  localparam logic [HASH_W-1:0] HASH_MOD  = 30'd1000000007;
  localparam logic [MULB_W-1:0] HASH_BASE = 6'd26;

  typedef enum logic [CMD_W-1:0] {
    CMD_PATTERN = 2'd0,
    CMD_TEXT    = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  typedef logic [HASH_W-1:0] hash_t;

  function automatic hash_t add_mod(hash_t x, hash_t y);
    logic [HASH_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, HASH_MOD}) s = s - {1'b0, HASH_MOD};
    return s[HASH_W-1:0];
  endfunction

  function automatic hash_t sub_mod(hash_t x, hash_t y);
    logic [HASH_W:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else s = {1'b0, x} + {1'b0, HASH_MOD} - {1'b0, y};
    return s[HASH_W-1:0];
  endfunction

  // one shift-add step of a modular multiply, msb first
  function automatic hash_t mul_step(hash_t acc, hash_t a, logic b);
    hash_t t;
    t = add_mod(acc, acc);
    if (b) t = add_mod(t, a);
    return t;
  endfunction

endpackage

>>> rtl/rolling_hash_substring_search.sv
// top level: rolling hash substring search with pattern and window memories
//
// channel  dir  handshake              payload
// in       in   in_valid_i/in_stall_o  cmd_i, letter_i, last_i
// out      out  out_valid_o/out_stall_i found_o, position_o
//
// pattern letter: weight then hash multiply (hash only for the first); ignored once full
// text letter: drop oldest letter if window full, add new one, compare on a hash hit
// all multiplies share one 6-step shift-add modular multiplier
// reset clears all control state; the two letter memories are not cleared
// a stalled result holds the last step of an item that has a result to give
`timescale 1ns / 1ps
module rolling_hash_substring_search #(
  parameter int unsigned     MAX_PATTERN = rhss_pkg::MAX_PATTERN_DEF,
  parameter longint unsigned MAX_TEXT    = rhss_pkg::MAX_TEXT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rhss_pkg::CMD_W-1:0]  cmd_i,
  input  logic [rhss_pkg::CODE_W-1:0] letter_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [rhss_pkg::POS_W-1:0]  position_o
);

  import rhss_pkg::*;

  localparam int IDXW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW   = $clog2(MAX_PATTERN + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT =
    (MAX_TEXT < 64'd131071) ? CNT_W'(MAX_TEXT) : 17'd131071;
  localparam logic [LW-1:0] PAT_MAX = LW'(MAX_PATTERN);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P_W  = 4'd1;
  localparam logic [3:0] S_P_H  = 4'd2;
  localparam logic [3:0] S_T_RD = 4'd3;
  localparam logic [3:0] S_T_DR = 4'd4;
  localparam logic [3:0] S_T_H  = 4'd5;
  localparam logic [3:0] S_C_RD = 4'd6;
  localparam logic [3:0] S_C_CK = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [CODE_W-1:0] letter_q, letter_d;
  logic              last_q, last_d;
  logic [LW-1:0]     plen_q, plen_d;
  hash_t             ph_q, ph_d, w_q, w_d, wh_q, wh_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              matched_q, matched_d, loading_q, loading_d;
  logic [IDXW-1:0]   head_q, head_d, idx_q, idx_d;
  hash_t             acc_q, acc_d, mul_a_q, mul_a_d;
  logic [MULB_W-1:0] mul_b_q, mul_b_d;
  logic [2:0]        mcnt_q, mcnt_d;
  logic              res_have_q, res_have_d;
  logic [POS_W-1:0]  res_pos_q, res_pos_d, start_q, start_d;
  logic              out_valid_q, out_valid_d, found_q, found_d;
  logic [POS_W-1:0]  pos_q, pos_d;

  logic              pram_we, wram_we;
  logic [IDXW-1:0]   wram_waddr, wram_raddr;
  logic [CODE_W-1:0] prd, wrd;

  hash_t             mstep, hsub, hnew;
  logic              mdone, seen_ge, p1_ge, emit_now, can_emit;
  logic [IDXW:0]     ring_sum, head_inc;
  logic [IDXW-1:0]   cmp_idx, head_nxt;
  logic [CNT_W:0]    start_full;
  hash_t             letter_w;

  assign mstep    = mul_step(acc_q, mul_a_q, mul_b_q[3'd5 - mcnt_q]);
  assign mdone    = (mcnt_q == 3'd5);
  assign seen_ge  = (cnt_q >= CNT_W'(plen_q));
  assign p1_ge    = ((CNT_W+1)'(cnt_q) + 1'b1) >= (CNT_W+1)'(plen_q);
  assign start_full = (CNT_W+1)'(cnt_q) + 1'b1 - (CNT_W+1)'(plen_q);
  assign letter_w = HASH_W'(letter_q) + 1'b1;
  assign hsub     = sub_mod(wh_q, mstep);
  assign hnew     = add_mod(mstep, letter_w);
  assign ring_sum = (IDXW+1)'(head_q) + (IDXW+1)'(idx_q);
  assign cmp_idx  = (ring_sum >= (IDXW+1)'(plen_q)) ?
                    IDXW'(ring_sum - (IDXW+1)'(plen_q)) : ring_sum[IDXW-1:0];
  assign head_inc = (IDXW+1)'(head_q) + 1'b1;
  assign head_nxt = (head_inc == (IDXW+1)'(plen_q)) ? '0 : head_inc[IDXW-1:0];
  assign emit_now = res_have_q || (last_q && !matched_q);
  assign can_emit = !out_valid_q || !out_stall_i;
  assign wram_raddr = (state_q == S_C_RD) ? cmp_idx : head_q;
  assign wram_waddr = seen_ge ? head_q : cnt_q[IDXW-1:0];

  rhss_ram #(.WIDTH(CODE_W), .DEPTH(MAX_PATTERN)) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (pram_we),
    .waddr_i (plen_q[IDXW-1:0]),
    .wdata_i (letter_q),
    .raddr_i (idx_q),
    .rdata_o (prd)
  );

  rhss_ram #(.WIDTH(CODE_W), .DEPTH(MAX_PATTERN)) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (wram_we),
    .waddr_i (wram_waddr),
    .wdata_i (letter_q),
    .raddr_i (wram_raddr),
    .rdata_o (wrd)
  );

  always_comb begin
    state_d = state_q;   letter_d = letter_q;   last_d = last_q;
    plen_d = plen_q;     ph_d = ph_q;           w_d = w_q;
    wh_d = wh_q;         cnt_d = cnt_q;         matched_d = matched_q;
    loading_d = loading_q; head_d = head_q;     idx_d = idx_q;
    acc_d = acc_q;       mul_a_d = mul_a_q;     mul_b_d = mul_b_q;
    mcnt_d = mcnt_q;     res_have_d = res_have_q; res_pos_d = res_pos_q;
    start_d = start_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d = found_q;   pos_d = pos_q;
    pram_we = 1'b0;      wram_we = 1'b0;

    if (state_q != S_IDLE && !mdone) begin
      acc_d  = mstep;
      mcnt_d = mcnt_q + 3'd1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          letter_d   = letter_i;
          last_d     = last_i;
          res_have_d = 1'b0;
          acc_d      = '0;
          mcnt_d     = '0;
          mul_b_d    = HASH_BASE;
          case (cmd_e'(cmd_i))
            CMD_PATTERN: begin
              loading_d = !last_i;
              if (!loading_q) begin
                plen_d = '0;  ph_d = '0;  w_d = HASH_W'(1);
                wh_d = '0;  cnt_d = '0;  matched_d = 1'b0;  head_d = '0;
                mul_a_d = '0;
                state_d = S_P_H;
              end else if (plen_q < PAT_MAX) begin
                mul_a_d = (plen_q != '0) ? w_q : ph_q;
                state_d = (plen_q != '0) ? S_P_W : S_P_H;
              end
            end
            CMD_TEXT: begin
              loading_d = 1'b0;
              if (matched_q) begin
                state_d = S_FIN;
              end else if (plen_q == '0) begin
                res_have_d = 1'b1;
                res_pos_d  = '0;
                matched_d  = 1'b1;
                state_d    = S_FIN;
              end else begin
                state_d = S_T_RD;
              end
            end
            CMD_CLEAR: begin
              loading_d = 1'b0;
              plen_d = '0;  ph_d = '0;  w_d = HASH_W'(1);
              wh_d = '0;  cnt_d = '0;  matched_d = 1'b0;  head_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_P_W: begin
        if (mdone) begin
          w_d = mstep;
          acc_d = '0;  mcnt_d = '0;  mul_a_d = ph_q;  mul_b_d = HASH_BASE;
          state_d = S_P_H;
        end
      end
      S_P_H: begin
        if (mdone) begin
          ph_d    = hnew;
          pram_we = 1'b1;
          plen_d  = plen_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      S_T_RD: begin
        acc_d = '0;
        mcnt_d = '0;
        if (seen_ge) begin
          mul_a_d = w_q;
          mul_b_d = MULB_W'(wrd) + 1'b1;
          state_d = S_T_DR;
        end else begin
          mul_a_d = wh_q;
          mul_b_d = HASH_BASE;
          state_d = S_T_H;
        end
      end
      S_T_DR: begin
        if (mdone) begin
          wh_d = hsub;
          acc_d = '0;  mcnt_d = '0;  mul_a_d = hsub;  mul_b_d = HASH_BASE;
          state_d = S_T_H;
        end
      end
      S_T_H: begin
        if (mdone) begin
          wh_d    = hnew;
          wram_we = 1'b1;
          if (seen_ge) head_d = head_nxt;
          if (cnt_q < CNT_LIMIT) cnt_d = cnt_q + 1'b1;
          start_d = (start_full > (CNT_W+1)'(16'hFFFF)) ? 16'hFFFF : start_full[POS_W-1:0];
          idx_d   = '0;
          state_d = (p1_ge && hnew == ph_q) ? S_C_RD : S_FIN;
        end
      end
      S_C_RD: begin
        state_d = S_C_CK;
      end
      S_C_CK: begin
        if (prd != wrd) begin
          state_d = S_FIN;
        end else if (LW'(idx_q) + 1'b1 == plen_q) begin
          res_have_d = 1'b1;
          res_pos_d  = start_q;
          matched_d  = 1'b1;
          state_d    = S_FIN;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_C_RD;
        end
      end
      S_FIN: begin
        if (!emit_now || can_emit) begin
          if (emit_now) begin
            out_valid_d = 1'b1;
            found_d     = res_have_q;
            pos_d       = res_have_q ? res_pos_q : '0;
          end
          if (last_q) begin
            wh_d = '0;  cnt_d = '0;  matched_d = 1'b0;  head_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      plen_q      <= '0;
      ph_q        <= '0;
      w_q         <= HASH_W'(1);
      wh_q        <= '0;
      cnt_q       <= '0;
      matched_q   <= 1'b0;
      loading_q   <= 1'b0;
      head_q      <= '0;
      mcnt_q      <= '0;
      res_have_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plen_q      <= plen_d;
      ph_q        <= ph_d;
      w_q         <= w_d;
      wh_q        <= wh_d;
      cnt_q       <= cnt_d;
      matched_q   <= matched_d;
      loading_q   <= loading_d;
      head_q      <= head_d;
      mcnt_q      <= mcnt_d;
      res_have_q  <= res_have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    letter_q  <= letter_d;
    last_q    <= last_d;
    idx_q     <= idx_d;
    acc_q     <= acc_d;
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    res_pos_q <= res_pos_d;
    start_q   <= start_d;
    found_q   <= found_d;
    pos_q     <= pos_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;

  a_notfound_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> position_o == '0)
    else $error("not-found result with nonzero position");

  a_hash_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wh_q < HASH_MOD && ph_q < HASH_MOD && w_q < HASH_MOD)
    else $error("hash register out of modular range");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q == '0 || LW'(head_q) < plen_q)
    else $error("window head beyond pattern length");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mcnt_q <= 3'd5)
    else $error("multiplier step count overrun");

endmodule

>>> rtl/rhss_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module rhss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
